>>> src/phtc_pkg.sv
// package for the per-host traffic counter: widths, codes, queue entry type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package phtc_pkg;
    localparam int TABLE_ENTRIES_DEFAULT = 256;
    localparam int ADDR_W = 32;
    localparam int LEN_W = 16;
    localparam int CNT_W = 32;
    localparam logic [CNT_W:0] COUNT_LIMIT = 33'h1_0000_0000 >> 1;

    typedef enum logic [1:0] {
        CFG_FILTER_ENABLE = 2'd0,
        CFG_LOCAL_NETWORK = 2'd1,
        CFG_LOCAL_MASK    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_NEW_HOST   = 2'd0,
        KIND_TOTALS     = 2'd1,
        KIND_CLEARED    = 2'd2,
        KIND_TABLE_FULL = 2'd3
    } report_kind_t;

    // classified packet passed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] host;
        logic              outbound;
        logic [LEN_W-1:0]  len;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_UPDATE,
        ST_EMIT1,
        ST_EMIT2,
        ST_WAIT
    } back_state_t;
endpackage
`default_nettype wire

>>> src/per_host_traffic_counter.sv
// top level of the per-host traffic counter: front classifier and back table engine
// depends on phtc_pkg, phtc_front, phtc_back
// flow: classify in the accept cycle into a two-entry queue, then a linear scan of the
// used table entries; on a threshold crossing a totals report is followed by a cleared
// report (the linear scan sets the rate)
// the back end takes a new packet from the queue only once it is done with the last one
// reset: synchronous active-low aresetn clears registers, table fill count and queues
`timescale 1ns / 1ps
`default_nettype none
module per_host_traffic_counter
    import phtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // source_address, destination_address, packet_length
    input  wire logic [79:0] s_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // host_address, sent_total, received_total
    output logic [95:0]      m_tdata,
    // report_kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    logic  q_valid, q_ready;
    work_t q_data;

    phtc_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_data
    );

    phtc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
endmodule
`default_nettype wire

>>> src/phtc_front.sv
// front end: config registers and packet classification into a work queue
// depends on phtc_pkg
`timescale 1ns / 1ps
`default_nettype none
module phtc_front
    import phtc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [79:0]           s_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output work_t                      q_data
);
    logic              enable_reg;
    logic [ADDR_W-1:0] network_reg, mask_reg;
    logic [ADDR_W-1:0] src, dst;
    logic              src_in, dst_in, keep;
    work_t             w;
    work_t             fifo_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              push, pop;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            network_reg <= '0;
            mask_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_FILTER_ENABLE) enable_reg <= cfg_data[0];
            if (cfg_index == CFG_LOCAL_NETWORK) network_reg <= cfg_data;
            if (cfg_index == CFG_LOCAL_MASK) mask_reg <= cfg_data;
        end
    end

    // classify
    assign src = s_tdata[31:0];
    assign dst = s_tdata[63:32];
    assign src_in = (src & mask_reg) == network_reg;
    assign dst_in = (dst & mask_reg) == network_reg;
    assign keep = enable_reg && (src_in != dst_in);
    always_comb begin
        w.host = src_in ? src : dst;
        w.outbound = src_in;
        w.len = s_tdata[79:64];
    end

    // two-entry queue
    assign s_tready = count_reg != 2'd2;
    assign push = s_tvalid && s_tready && keep;
    assign q_valid = count_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign q_data = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

>>> src/phtc_back.sv
// back end: host table lookup, counter update and report generation
// depends on phtc_pkg
`timescale 1ns / 1ps
`default_nettype none
module phtc_back
    import phtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire work_t        q_data,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    // host/sent/received memories, one read port each
    logic [ADDR_W-1:0] host_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0]  sent_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0]  recv_mem [TABLE_ENTRIES];

    back_state_t state_reg, state_next;
    work_t       item_reg, item_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] scan_reg, scan_next;
    logic              rd_pending_reg, rd_pending_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0] rd_host_reg;
    logic [CNT_W-1:0]  rd_sent_reg, rd_recv_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [CNT_W-1:0]  wr_sent, wr_recv;
    logic              host_we;
    logic [CNT_W-1:0]  sum_sent, sum_recv;
    logic [CNT_W-1:0]  tot_sent_reg, tot_sent_next, tot_recv_reg, tot_recv_next;
    logic [95:0]       o_data_reg, o_data_next;
    logic [1:0]        o_user_reg, o_user_next;
    logic              o_last_reg, o_last_next, o_valid_reg, o_valid_next;
    logic              o_free;

    assign m_tvalid = o_valid_reg;
    assign m_tdata = o_data_reg;
    assign m_tuser = o_user_reg;
    assign m_tlast = o_last_reg;
    assign o_free = !o_valid_reg || m_tready;

    // memory access
    always_ff @(posedge aclk) begin
        if (host_we) host_mem[slot_reg] <= item_reg.host;
        if (mem_we) begin
            sent_mem[slot_reg] <= wr_sent;
            recv_mem[slot_reg] <= wr_recv;
        end
        rd_host_reg <= host_mem[rd_addr];
        rd_sent_reg <= sent_mem[rd_addr];
        rd_recv_reg <= recv_mem[rd_addr];
    end

    assign sum_sent = rd_sent_reg + (item_reg.outbound ? CNT_W'(item_reg.len) : '0);
    assign sum_recv = rd_recv_reg + (item_reg.outbound ? '0 : CNT_W'(item_reg.len));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            rd_pending_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            rd_pending_reg <= rd_pending_next;
            o_valid_reg <= o_valid_next;
        end
        item_reg <= item_next;
        scan_reg <= scan_next;
        slot_reg <= slot_next;
        tot_sent_reg <= tot_sent_next;
        tot_recv_reg <= tot_recv_next;
        o_data_reg <= o_data_next;
        o_user_reg <= o_user_next;
        o_last_reg <= o_last_next;
    end

    // sequencer: linear scan of used entries, then read-modify-write
    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        used_next = used_reg;
        scan_next = scan_reg;
        slot_next = slot_reg;
        rd_pending_next = 1'b0;
        tot_sent_next = tot_sent_reg;
        tot_recv_next = tot_recv_reg;
        o_data_next = o_data_reg;
        o_user_next = o_user_reg;
        o_last_next = o_last_reg;
        o_valid_next = o_valid_reg && !m_tready;
        q_ready = 1'b0;
        rd_addr = scan_reg[IDX_W-1:0];
        mem_we = 1'b0;
        host_we = 1'b0;
        wr_sent = '0;
        wr_recv = '0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next = q_data;
                    scan_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue read of scan_reg, check the previous read
                if (rd_pending_reg && rd_host_reg == item_reg.host) begin
                    rd_addr = slot_reg;
                    rd_pending_next = 1'b1;
                    state_next = ST_UPDATE;
                end else if (scan_reg == used_reg) begin
                    if (used_reg == USED_W'(TABLE_ENTRIES)) begin
                        if (o_free) begin
                            o_data_next = {64'd0, item_reg.host};
                            o_user_next = KIND_TABLE_FULL;
                            o_last_next = 1'b1;
                            o_valid_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        slot_next = used_reg[IDX_W-1:0];
                        state_next = ST_INSERT;
                    end
                end else begin
                    slot_next = scan_reg[IDX_W-1:0];
                    rd_pending_next = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_INSERT: begin
                if (o_free) begin
                    host_we = 1'b1;
                    mem_we = 1'b1;
                    wr_sent = item_reg.outbound ? CNT_W'(item_reg.len) : '0;
                    wr_recv = item_reg.outbound ? '0 : CNT_W'(item_reg.len);
                    used_next = used_reg + 1'b1;
                    o_data_next = {64'd0, item_reg.host};
                    o_user_next = KIND_NEW_HOST;
                    o_last_next = 1'b1;
                    o_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE: begin
                // read data for slot arrives now
                mem_we = 1'b1;
                tot_sent_next = sum_sent;
                tot_recv_next = sum_recv;
                if ({1'b0, sum_sent} > COUNT_LIMIT || {1'b0, sum_recv} > COUNT_LIMIT) begin
                    state_next = ST_EMIT1;
                end else begin
                    wr_sent = sum_sent;
                    wr_recv = sum_recv;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT1: begin
                if (o_free) begin
                    o_data_next = {tot_recv_reg, tot_sent_reg, item_reg.host};
                    o_user_next = KIND_TOTALS;
                    o_last_next = 1'b0;
                    o_valid_next = 1'b1;
                    state_next = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                if (o_free) begin
                    o_data_next = {64'd0, item_reg.host};
                    o_user_next = KIND_CLEARED;
                    o_last_next = 1'b1;
                    o_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
